[rtl/core/brhq_pkg.sv]
`timescale 1ns / 1ps

package brhq_pkg;

   // Widths of the sample paths and of the configuration port.
   localparam int SAMPLE_W    = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PRODUCT_W   = 2 * SAMPLE_W;

   // Block constants.
   localparam int UPDATE_PERIOD     = 20;
   localparam int FILTER_SHIFT      = 3;
   localparam int DEFAULT_THRESHOLD = 1400;

   localparam logic [SAMPLE_W-1:0] SAMPLE_LOST_LEVEL = 12'd4090;
   localparam logic [SAMPLE_W:0]   FULL_SCALE        = 13'd4095;
   localparam logic [15:0]         TIMER_CAP         = 16'd60000;
   localparam logic [7:0]          RUN_CAP           = 8'd255;
   localparam logic [7:0]          UPDATE_COUNT      = UPDATE_PERIOD[7:0];

   localparam logic [15:0] ACCUM_RESET =
      16'((DEFAULT_THRESHOLD << FILTER_SHIFT) & 16'hFFFF);
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = DEFAULT_THRESHOLD[SAMPLE_W-1:0];

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_MIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_MAX = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT_MARGIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_MARGIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_CONFIRM    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_CONFIRM   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_TIMEOUT  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_ON       = 3'd7;

   // Operation codes of an input item.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_POLL = 1'b1;

   typedef struct packed {
      logic                operation;
      logic                pin_level;
      logic [SAMPLE_W-1:0] signal_sample;
      logic [SAMPLE_W-1:0] pot_sample_a;
      logic [SAMPLE_W-1:0] pot_sample_b;
      logic [SAMPLE_W-1:0] pot_sample_c;
      logic [SAMPLE_W-1:0] pot_sample_d;
   } brhq_req_type;

   typedef struct packed {
      logic                light_present;
      logic                no_output;
      logic                nc_output;
      logic [SAMPLE_W-1:0] threshold_now;
   } brhq_rsp_type;

   // The part of an item that travels past the pot mapping stages.
   typedef struct packed {
      logic                operation;
      logic                pin_level;
      logic [SAMPLE_W-1:0] signal_sample;
   } brhq_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] threshold_min;
      logic [SAMPLE_W-1:0] threshold_max;
      logic [9:0]          light_margin;
      logic [9:0]          dark_margin;
      logic [7:0]          on_confirm;
      logic [7:0]          off_confirm;
      logic [15:0]         lost_timeout;
      logic                dark_on;
   } brhq_cfg_type;

   typedef struct packed {
      logic                prev_pin_level;
      logic                pin_seen;
      logic                light_flag;
      logic [7:0]          light_run;
      logic [7:0]          dark_run;
      logic [15:0]         ticks_since_edge;
      logic [7:0]          update_ticks;
      logic [15:0]         threshold_accum;
      logic [SAMPLE_W-1:0] threshold_reg;
   } brhq_state_type;

   localparam brhq_cfg_type CFG_RESET = '{
      threshold_min: 12'd700,
      threshold_max: 12'd2800,
      light_margin:  10'd80,
      dark_margin:   10'd80,
      on_confirm:    8'd2,
      off_confirm:   8'd3,
      lost_timeout:  16'd8,
      dark_on:       1'b0
   };

   localparam brhq_state_type STATE_RESET = '{
      prev_pin_level:   1'b0,
      pin_seen:         1'b0,
      light_flag:       1'b0,
      light_run:        8'd0,
      dark_run:         8'd0,
      ticks_since_edge: 16'd8,
      update_ticks:     8'd0,
      threshold_accum:  ACCUM_RESET,
      threshold_reg:    THRESHOLD_RESET
   };

endpackage

[rtl/core/brhq_trim.sv]
`timescale 1ns / 1ps

// Trimmed mean of the four pot samples: drop the lowest and the highest,
// then halve the sum of the middle two.
module brhq_trim (
   input  brhq_pkg::brhq_req_type          item,
   output logic [brhq_pkg::SAMPLE_W-1:0]   trimmed
);
   import brhq_pkg::*;

   logic [SAMPLE_W-1:0] lo_ab, lo_cd, hi_ab, hi_cd, lo_all, hi_all;
   logic [SAMPLE_W+1:0] sum_all;
   logic [SAMPLE_W:0]   middle_sum;

   always_comb begin
      lo_ab  = (item.pot_sample_b < item.pot_sample_a) ? item.pot_sample_b : item.pot_sample_a;
      hi_ab  = (item.pot_sample_b > item.pot_sample_a) ? item.pot_sample_b : item.pot_sample_a;
      lo_cd  = (item.pot_sample_d < item.pot_sample_c) ? item.pot_sample_d : item.pot_sample_c;
      hi_cd  = (item.pot_sample_d > item.pot_sample_c) ? item.pot_sample_d : item.pot_sample_c;
      lo_all = (lo_cd < lo_ab) ? lo_cd : lo_ab;
      hi_all = (hi_cd > hi_ab) ? hi_cd : hi_ab;
      sum_all = {2'b00, item.pot_sample_a} + {2'b00, item.pot_sample_b}
              + {2'b00, item.pot_sample_c} + {2'b00, item.pot_sample_d};
      // The middle two samples never sum past one bit above a sample.
      middle_sum = (SAMPLE_W + 1)'(sum_all - {2'b00, lo_all} - {2'b00, hi_all});
      trimmed = middle_sum[SAMPLE_W:1];
   end

endmodule

[rtl/core/brhq_div_full_scale.sv]
`timescale 1ns / 1ps

// Divides a product of two samples by full scale (2^12 - 1) and adds the
// mapping base. With full scale one below a power of two, the high part of
// the product is a quotient that is at most one short; the remainder then
// stays below twice full scale, so one compare corrects it.
module brhq_div_full_scale (
   input  logic [brhq_pkg::PRODUCT_W-1:0] product,
   input  logic [brhq_pkg::SAMPLE_W-1:0]  base,
   output logic [brhq_pkg::SAMPLE_W-1:0]  mapped
);
   import brhq_pkg::*;

   logic [SAMPLE_W-1:0] quot_est;
   logic [SAMPLE_W:0]   remainder;
   logic [SAMPLE_W:0]   quotient;
   logic [SAMPLE_W:0]   mapped_wide;

   always_comb begin
      quot_est  = product[PRODUCT_W-1:SAMPLE_W];
      remainder = {1'b0, product[SAMPLE_W-1:0]} + {1'b0, quot_est};
      quotient  = (remainder >= FULL_SCALE) ? {1'b0, quot_est} + 13'd1 : {1'b0, quot_est};
      // The quotient never exceeds the span, so the sum stays within a sample.
      mapped_wide = {1'b0, base} + quotient;
      mapped      = mapped_wide[SAMPLE_W-1:0];
   end

endmodule

[rtl/core/brhq_qualify.sv]
`timescale 1ns / 1ps

// Per-item state update: lost timer, edge detection, hysteresis judgment
// with confirm counters, and the smoothed threshold update on ticks.
module brhq_qualify (
   input  brhq_pkg::brhq_cfg_type          cfg,
   input  brhq_pkg::brhq_state_type        state_now,
   input  brhq_pkg::brhq_item_type         item,
   input  logic [brhq_pkg::SAMPLE_W-1:0]   mapped,
   output brhq_pkg::brhq_state_type        state_next,
   output brhq_pkg::brhq_rsp_type          result
);
   import brhq_pkg::*;

   logic [15:0]         ticks_aged;
   logic [7:0]          period_count;
   logic [SAMPLE_W:0]   on_level;
   logic [SAMPLE_W-1:0] off_level;
   logic                is_light;
   logic                is_dark;
   logic                rising;
   logic [15:0]         accum_keep;
   logic [15:0]         accum_sum;
   logic [15:0]         thr_wide;
   logic [SAMPLE_W-1:0] thr_clamped;
   logic                active;

   function automatic brhq_state_type apply_loss(brhq_state_type s, logic [7:0] off_confirm);
      brhq_state_type r;
      r            = s;
      r.light_flag = 1'b0;
      r.light_run  = '0;
      if (r.dark_run < off_confirm) begin
         r.dark_run = off_confirm;
      end
      return r;
   endfunction

   always_comb begin
      ticks_aged   = (state_now.ticks_since_edge < TIMER_CAP) ?
                     state_now.ticks_since_edge + 16'd1 : state_now.ticks_since_edge;
      period_count = state_now.update_ticks + 8'd1;

      on_level  = {1'b0, state_now.threshold_reg} + {3'b000, cfg.light_margin};
      off_level = (state_now.threshold_reg > {2'b00, cfg.dark_margin}) ?
                  state_now.threshold_reg - {2'b00, cfg.dark_margin} : '0;
      is_light  = {1'b0, item.signal_sample} >= on_level;
      is_dark   = item.signal_sample <= off_level;
      rising    = !state_now.prev_pin_level && item.pin_level;

      accum_keep = state_now.threshold_accum - (state_now.threshold_accum >> FILTER_SHIFT);
      accum_sum  = accum_keep + {4'b0000, mapped};
      thr_wide   = accum_sum >> FILTER_SHIFT;
      // Low bound tested first: if max < min, values below min give min, others max.
      if (thr_wide < {4'b0000, cfg.threshold_min}) begin
         thr_clamped = cfg.threshold_min;
      end else if (thr_wide > {4'b0000, cfg.threshold_max}) begin
         thr_clamped = cfg.threshold_max;
      end else begin
         thr_clamped = thr_wide[SAMPLE_W-1:0];
      end

      state_next = state_now;
      if (item.operation == OP_TICK) begin
         state_next.ticks_since_edge = ticks_aged;
         if (ticks_aged >= cfg.lost_timeout) begin
            state_next = apply_loss(state_next, cfg.off_confirm);
         end
         state_next.update_ticks = period_count;
         if (period_count >= UPDATE_COUNT) begin
            state_next.update_ticks    = '0;
            state_next.threshold_accum = accum_sum;
            state_next.threshold_reg   = thr_clamped;
         end
      end else if (!state_now.pin_seen) begin
         state_next.pin_seen       = 1'b1;
         state_next.prev_pin_level = item.pin_level;
      end else begin
         if (rising) begin
            state_next.ticks_since_edge = '0;
            if (item.signal_sample < SAMPLE_LOST_LEVEL) begin
               if (is_light) begin
                  if (state_next.light_run < RUN_CAP) begin
                     state_next.light_run = state_next.light_run + 8'd1;
                  end
                  state_next.dark_run = '0;
               end else if (is_dark) begin
                  if (state_next.dark_run < RUN_CAP) begin
                     state_next.dark_run = state_next.dark_run + 8'd1;
                  end
                  state_next.light_run = '0;
               end
               if (!state_next.light_flag && state_next.light_run >= cfg.on_confirm) begin
                  state_next.light_flag = 1'b1;
               end
               if (state_next.light_flag && state_next.dark_run >= cfg.off_confirm) begin
                  state_next.light_flag = 1'b0;
               end
            end else begin
               state_next = apply_loss(state_next, cfg.off_confirm);
            end
         end
         state_next.prev_pin_level = item.pin_level;
      end

      active = cfg.dark_on ? !state_next.light_flag : state_next.light_flag;
      result.light_present = state_next.light_flag;
      result.no_output     = active;
      result.nc_output     = !active;
      result.threshold_now = state_next.threshold_reg;
   end

endmodule

[rtl/core/beam_receiver_hysteresis_qualifier.sv]
`timescale 1ns / 1ps

// Beam receiver qualifier with hysteresis and debounce.
//
// Input items arrive on the req_ channel: a tick item ages the lost timer
// and, every twentieth tick, folds the mapped trimmed mean of its four pot
// samples into the smoothed threshold; a poll item samples the pulse pin and,
// on a rising edge, judges the light sample against the hysteresis window.
// Every item yields exactly one result item on the rsp_ channel, in order.
// Configuration registers are written through the csr_ channel, which is
// always ready; write them only while no item is in flight.
//
// Items move through stages 0 to 3 into the result register. The pipeline
// takes one item per cycle unless the receiver stalls: three stages compute
// the pot mapping (trimmed mean, 12x12 multiply, divide by full scale), and
// the last stage updates the qualifier state and loads the result register.
// When the receiver stalls, items back up stage by stage; req_ready drops
// only once every stage holds an item. Reset empties the pipeline, restores
// register defaults and returns the qualifier state to its start-up values.
module beam_receiver_hysteresis_qualifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  brhq_pkg::brhq_req_type               req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output brhq_pkg::brhq_rsp_type               rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [brhq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [brhq_pkg::CSR_DATA_W-1:0]      csr_data
);
   import brhq_pkg::*;

   // Pipeline registers. Stage 0 holds the accepted item, stage 1 the
   // trimmed mean, stage 2 the product and stage 3 the mapped pot value.
   logic                 s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   brhq_req_type         s0_item_ff;
   brhq_item_type        s1_item_ff, s2_item_ff, s3_item_ff;
   logic [SAMPLE_W-1:0]  s1_trim_ff;
   logic [PRODUCT_W-1:0] s2_product_ff;
   logic [SAMPLE_W-1:0]  s3_mapped_ff;
   brhq_rsp_type         rsp_payload_ff;

   brhq_cfg_type         cfg_ff, cfg_in;
   brhq_state_type       state_ff, state_in;
   brhq_rsp_type         result;

   logic                 s0_en, s1_en, s2_en, s3_en, rsp_en;
   logic [SAMPLE_W-1:0]  trimmed;
   logic [SAMPLE_W-1:0]  span;
   logic [SAMPLE_W-1:0]  mapped;
   brhq_item_type        s0_item_short;

   // A stage may load whenever it is empty or its occupant moves on.
   assign rsp_en = !rsp_valid_ff || rsp_ready;
   assign s3_en  = !s3_valid_ff || rsp_en;
   assign s2_en  = !s2_valid_ff || s3_en;
   assign s1_en  = !s1_valid_ff || s2_en;
   assign s0_en  = !s0_valid_ff || s1_en;

   assign req_ready   = s0_en;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

   assign s0_item_short = '{operation:     s0_item_ff.operation,
                            pin_level:     s0_item_ff.pin_level,
                            signal_sample: s0_item_ff.signal_sample};

   // A max below min gives an empty span, so the map lands on min.
   assign span = (cfg_ff.threshold_max >= cfg_ff.threshold_min) ?
                 cfg_ff.threshold_max - cfg_ff.threshold_min : '0;

   brhq_trim u_trim (
      .item    (s0_item_ff),
      .trimmed (trimmed)
   );

   brhq_div_full_scale u_div (
      .product (s2_product_ff),
      .base    (cfg_ff.threshold_min),
      .mapped  (mapped)
   );

   brhq_qualify u_qualify (
      .cfg        (cfg_ff),
      .state_now  (state_ff),
      .item       (s3_item_ff),
      .mapped     (s3_mapped_ff),
      .state_next (state_in),
      .result     (result)
   );

   // Register writes; indexes cover all eight registers.
   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_index)
         CSR_THRESHOLD_MIN: cfg_in.threshold_min = csr_data[SAMPLE_W-1:0];
         CSR_THRESHOLD_MAX: cfg_in.threshold_max = csr_data[SAMPLE_W-1:0];
         CSR_LIGHT_MARGIN:  cfg_in.light_margin  = csr_data[9:0];
         CSR_DARK_MARGIN:   cfg_in.dark_margin   = csr_data[9:0];
         CSR_ON_CONFIRM:    cfg_in.on_confirm    = csr_data[7:0];
         CSR_OFF_CONFIRM:   cfg_in.off_confirm   = csr_data[7:0];
         CSR_LOST_TIMEOUT:  cfg_in.lost_timeout  = csr_data[15:0];
         CSR_DARK_ON:       cfg_in.dark_on       = csr_data[0];
      endcase
   end

   // Control state: valid bits, registers and qualifier state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= CFG_RESET;
         state_ff     <= STATE_RESET;
      end else begin
         if (s0_en) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_en) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rsp_en) begin
            rsp_valid_ff <= s3_valid_ff;
         end
         // The state advances exactly once per item, as it enters the
         // result register.
         if (rsp_en && s3_valid_ff) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            cfg_ff <= cfg_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s0_en) begin
         s0_item_ff <= req_payload;
      end
      if (s1_en) begin
         s1_item_ff <= s0_item_short;
         s1_trim_ff <= trimmed;
      end
      if (s2_en) begin
         s2_item_ff    <= s1_item_ff;
         s2_product_ff <= {{SAMPLE_W{1'b0}}, s1_trim_ff} * {{SAMPLE_W{1'b0}}, span};
      end
      if (s3_en) begin
         s3_item_ff   <= s2_item_ff;
         s3_mapped_ff <= mapped;
      end
      if (rsp_en) begin
         rsp_payload_ff <= result;
      end
   end

endmodule

[rtl/core/brhq_checker.sv]
`timescale 1ns / 1ps

// Port-level checks of the qualifier.
module brhq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input brhq_pkg::brhq_rsp_type           rsp_payload
);
   import brhq_pkg::*;

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An accepted item, or one ahead of it, sits in the result register once
   // it has passed stages 0 to 3.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##5 rsp_valid)
      else $error("no result five edges after an accepted item");

   // With the result register empty, nothing in the pipeline can block.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input not ready while the result register is empty");

   // The two switch outputs are always complementary.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.nc_output != rsp_payload.no_output))
      else $error("switch outputs not complementary");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind beam_receiver_hysteresis_qualifier brhq_checker u_brhq_checker (.*);
